// ===== src/assert_macros.svh =====
// Assertion macros for the scanner RTL; crcjrs_queue uses them.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge, quiet while reset is asserted.
`define CHK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/crcjrs_pkg.sv =====
// Shared types, constants and the CRC32C byte step for the journal scanner.
// Used by crcjrs_front, crcjrs_queue and crc_journal_recovery_scanner.
package crcjrs_pkg;

	localparam int unsigned MAX_RECORD_LIMIT_DEF = 32'd1048576;
	localparam int unsigned QUEUE_DEPTH_DEF      = 4;
	localparam logic [31:0] JOURNAL_MAGIC        = 32'h314A4651;
	localparam logic [31:0] HEADER_LEN           = 32'd40;
	localparam logic [21:0] PREFIX_LEN           = 22'd10;
	localparam logic [31:0] CRC_POLY             = 32'h82F63B78;

	typedef enum logic [1:0] {
		CFG_MAX_RECORD  = 2'd0,
		CFG_MAX_IMAGE   = 2'd1,
		CFG_EXP_VERSION = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_RECORD  = 2'd1,
		KIND_SUMMARY = 2'd2
	} result_kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_HDR_SHORT   = 3'd1,
		ST_MAGIC_BAD   = 3'd2,
		ST_VERSION_BAD = 3'd3,
		ST_HDR_CRC_BAD = 3'd4,
		ST_CORRUPT     = 3'd5,
		ST_TOO_LARGE   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		TAIL_CLEAN = 2'd0,
		TAIL_TORN  = 2'd1,
		TAIL_MID   = 2'd2
	} tail_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_RECORD = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] record_kind;
		logic [20:0] record_len;
		logic [31:0] position;
		logic [63:0] boot_high;
		logic [63:0] boot_low;
		logic [63:0] epoch_value;
		logic [2:0]  status;
		logic [31:0] records_seen;
		logic [1:0]  tail_state;
		logic [31:0] torn_bytes;
		logic        last_result;
	} out_item_t;

	// Up to two results leave the front part for one byte.
	typedef struct packed {
		logic      v0;
		logic      v1;
		out_item_t r0;
		out_item_t r1;
	} push_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crcjrs_front.sv =====
// Front part: takes image bytes, parses header and records, checks CRCs
// and produces up to two results per byte. Depends on crcjrs_pkg.
module crcjrs_front #(
	parameter int unsigned MAX_RECORD_LIMIT = crcjrs_pkg::MAX_RECORD_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  crcjrs_pkg::in_item_t item,
	input  logic [20:0]         max_record_len,
	input  logic [31:0]         max_image_len,
	input  logic [15:0]         expected_version,
	output crcjrs_pkg::push_t   push
);

	crcjrs_pkg::phase_t phase_q, phase_n;
	logic [31:0] off_q, off_n;
	logic        ovf_q, ovf_n;
	logic [21:0] rel_q, rel_n;
	logic [63:0] fs_q, fs_n;
	logic [31:0] crc_q, crc_n;
	logic [63:0] boot_high_q, boot_high_n;
	logic [63:0] boot_low_q, boot_low_n;
	logic [63:0] epoch_q, epoch_n;
	logic [15:0] cur_type_q, cur_type_n;
	logic [31:0] cur_len_q, cur_len_n;
	logic [31:0] stored_q, stored_n;
	logic [31:0] cur_start_q, cur_start_n;
	logic [31:0] good_prefix_q, good_prefix_n;
	logic [31:0] seen_q, seen_n;
	logic [2:0]  verdict_q, verdict_n;
	logic [1:0]  tail_q, tail_n;
	logic        probing_q, probing_n;
	logic [2:0]  hdr_err_q, hdr_err_n;
	logic [31:0] bad_start_q, bad_start_n;
	logic [31:0] torn_start_q, torn_start_n;

	logic [20:0] lim;
	logic [5:0]  hi;
	logic [5:0]  sh;
	logic [63:0] fs_base;
	logic [7:0]  b;
	logic        finish;
	logic        good;
	logic [31:0] next_start;
	logic [32:0] size33;
	logic        too_large;
	crcjrs_pkg::out_item_t res;
	crcjrs_pkg::push_t     push_c;

	assign lim = ({11'd0, max_record_len} > 32'(MAX_RECORD_LIMIT)) ?
		21'(MAX_RECORD_LIMIT) : max_record_len;
	assign b = item.data_byte;

	always_comb begin
		phase_n       = phase_q;
		off_n         = off_q + 32'd1;
		ovf_n         = ovf_q | (off_q == '1);
		rel_n         = rel_q;
		fs_n          = fs_q;
		crc_n         = crc_q;
		boot_high_n   = boot_high_q;
		boot_low_n    = boot_low_q;
		epoch_n       = epoch_q;
		cur_type_n    = cur_type_q;
		cur_len_n     = cur_len_q;
		stored_n      = stored_q;
		cur_start_n   = cur_start_q;
		good_prefix_n = good_prefix_q;
		seen_n        = seen_q;
		verdict_n     = verdict_q;
		tail_n        = tail_q;
		probing_n     = probing_q;
		hdr_err_n     = hdr_err_q;
		bad_start_n   = bad_start_q;
		torn_start_n  = torn_start_q;
		hi            = off_q[5:0];
		sh            = '0;
		fs_base       = fs_q;
		finish        = 1'b0;
		good          = 1'b0;
		next_start    = cur_start_q + 32'(crcjrs_pkg::PREFIX_LEN) + cur_len_q;
		size33        = {1'b0, off_q} + 33'd1;
		too_large     = ovf_q || (size33 > {1'b0, max_image_len});
		res           = '0;
		push_c        = '0;

		case (phase_q)
			crcjrs_pkg::PH_HEADER: begin
				if (hi == 6'd0 || hi == 6'd4 || hi == 6'd8 || hi == 6'd16 ||
				    hi == 6'd24 || hi == 6'd32) begin
					fs_base = '0;
				end
				sh = (hi < 6'd8 || hi >= 6'd32) ? {1'b0, hi[1:0], 3'b000} : {hi[2:0], 3'b000};
				fs_n = fs_base | ({56'd0, b} << sh);
				if (hi < 6'd32) begin
					crc_n = crcjrs_pkg::crc32c_byte(crc_q, b);
				end
				if (hi == 6'd3 && fs_n[31:0] != crcjrs_pkg::JOURNAL_MAGIC && hdr_err_q == '0) begin
					hdr_err_n = crcjrs_pkg::ST_MAGIC_BAD;
				end
				if (hi == 6'd5 && fs_n[31:0] != {16'd0, expected_version} &&
				    hdr_err_q == '0) begin
					hdr_err_n = crcjrs_pkg::ST_VERSION_BAD;
				end
				if (hi == 6'd15) begin
					boot_high_n = fs_n;
				end
				if (hi == 6'd23) begin
					boot_low_n = fs_n;
				end
				if (hi == 6'd31) begin
					epoch_n = fs_n;
				end
				if (hi == 6'd35 && fs_n[31:0] != ~crc_q && hdr_err_q == '0) begin
					hdr_err_n = crcjrs_pkg::ST_HDR_CRC_BAD;
				end
				if (hi == 6'd39) begin
					if (hdr_err_n != '0) begin
						verdict_n = hdr_err_n;
						phase_n   = crcjrs_pkg::PH_DONE;
					end else begin
						res.result_kind = crcjrs_pkg::KIND_HEADER;
						res.position    = crcjrs_pkg::HEADER_LEN;
						res.boot_high   = boot_high_q;
						res.boot_low    = boot_low_q;
						res.epoch_value = epoch_q;
						push_c.v0       = 1'b1;
						push_c.r0       = res;
						phase_n         = crcjrs_pkg::PH_RECORD;
						cur_start_n     = crcjrs_pkg::HEADER_LEN;
						good_prefix_n   = crcjrs_pkg::HEADER_LEN;
						rel_n           = '0;
					end
				end
			end
			crcjrs_pkg::PH_RECORD: begin
				rel_n = rel_q + 22'd1;
				if (rel_q == '0) begin
					crc_n   = '1;
					fs_base = '0;
					if (!probing_q) begin
						seen_n = seen_q + 32'd1;
					end
				end else begin
					crc_n = crc_q;
				end
				if (rel_q < crcjrs_pkg::PREFIX_LEN) begin
					if (rel_q < 22'd2) begin
						sh = {rel_q[2:0], 3'b000};
					end else if (rel_q < 22'd6) begin
						sh = {3'(rel_q[2:0] - 3'd2), 3'b000};
					end else begin
						sh = {3'(rel_q[2:0] - 3'd6), 3'b000};
					end
					fs_n = fs_base | ({56'd0, b} << sh);
					if (rel_q < 22'd6) begin
						crc_n = crcjrs_pkg::crc32c_byte(crc_n, b);
					end
					if (rel_q == 22'd1) begin
						cur_type_n = fs_n[15:0];
						fs_n       = '0;
					end
					if (rel_q == 22'd5) begin
						cur_len_n = fs_n[31:0];
						fs_n      = '0;
					end
					if (rel_q == 22'd9) begin
						stored_n = fs_n[31:0];
						if (cur_len_q > {11'd0, lim}) begin
							tail_n       = crcjrs_pkg::TAIL_TORN;
							torn_start_n = probing_q ? bad_start_q : cur_start_q;
							phase_n      = crcjrs_pkg::PH_DONE;
						end else if (cur_len_q == '0) begin
							finish = 1'b1;
						end
					end
				end else begin
					crc_n = crcjrs_pkg::crc32c_byte(crc_q, b);
					if (rel_q == cur_len_q[21:0] + 22'd9) begin
						finish = 1'b1;
					end
				end
				if (finish) begin
					good  = (~crc_n == stored_n);
					rel_n = '0;
					if (!probing_q) begin
						if (good) begin
							res.result_kind  = crcjrs_pkg::KIND_RECORD;
							res.record_kind  = cur_type_q;
							res.record_len   = cur_len_q[20:0];
							res.position     = cur_start_q;
							res.records_seen = seen_n;
							push_c.v0        = 1'b1;
							push_c.r0        = res;
							good_prefix_n    = next_start;
						end else begin
							probing_n   = 1'b1;
							bad_start_n = cur_start_q;
						end
						cur_start_n = next_start;
					end else if (good) begin
						verdict_n = crcjrs_pkg::ST_CORRUPT;
						tail_n    = crcjrs_pkg::TAIL_MID;
						phase_n   = crcjrs_pkg::PH_DONE;
					end else begin
						tail_n       = crcjrs_pkg::TAIL_TORN;
						torn_start_n = bad_start_q;
						phase_n      = crcjrs_pkg::PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase

		if (item.final_byte) begin
			res             = '0;
			res.result_kind = crcjrs_pkg::KIND_SUMMARY;
			res.last_result = 1'b1;
			if (too_large) begin
				res.status = crcjrs_pkg::ST_TOO_LARGE;
			end else if (phase_n == crcjrs_pkg::PH_HEADER) begin
				res.status = crcjrs_pkg::ST_HDR_SHORT;
			end else if (verdict_n >= crcjrs_pkg::ST_HDR_SHORT &&
			             verdict_n <= crcjrs_pkg::ST_HDR_CRC_BAD) begin
				res.status = verdict_n;
			end else begin
				// An image that stops inside a record, or while probing, ends torn.
				if (phase_n == crcjrs_pkg::PH_RECORD) begin
					if (probing_n) begin
						tail_n       = crcjrs_pkg::TAIL_TORN;
						torn_start_n = bad_start_n;
					end else if (size33[31:0] > cur_start_n) begin
						tail_n       = crcjrs_pkg::TAIL_TORN;
						torn_start_n = cur_start_n;
					end
				end
				res.position     = good_prefix_n;
				res.status       = verdict_n;
				res.records_seen = seen_n;
				res.tail_state   = tail_n;
				if (tail_n == crcjrs_pkg::TAIL_TORN) begin
					res.torn_bytes = size33[31:0] - torn_start_n;
				end
			end
			if (push_c.v0) begin
				push_c.v1 = 1'b1;
				push_c.r1 = res;
			end else begin
				push_c.v0 = 1'b1;
				push_c.r0 = res;
			end
			phase_n       = crcjrs_pkg::PH_HEADER;
			off_n         = '0;
			ovf_n         = 1'b0;
			rel_n         = '0;
			fs_n          = '0;
			crc_n         = '1;
			boot_high_n   = '0;
			boot_low_n    = '0;
			epoch_n       = '0;
			cur_type_n    = '0;
			cur_len_n     = '0;
			stored_n      = '0;
			cur_start_n   = crcjrs_pkg::HEADER_LEN;
			good_prefix_n = crcjrs_pkg::HEADER_LEN;
			seen_n        = '0;
			verdict_n     = crcjrs_pkg::ST_OK;
			tail_n        = crcjrs_pkg::TAIL_CLEAN;
			probing_n     = 1'b0;
			hdr_err_n     = '0;
			bad_start_n   = '0;
			torn_start_n  = '0;
		end
	end

	always_comb begin
		push    = push_c;
		push.v0 = push_c.v0 & take;
		push.v1 = push_c.v1 & take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= crcjrs_pkg::PH_HEADER;
			off_q         <= '0;
			ovf_q         <= 1'b0;
			rel_q         <= '0;
			fs_q          <= '0;
			crc_q         <= '1;
			boot_high_q   <= '0;
			boot_low_q    <= '0;
			epoch_q       <= '0;
			cur_type_q    <= '0;
			cur_len_q     <= '0;
			stored_q      <= '0;
			cur_start_q   <= crcjrs_pkg::HEADER_LEN;
			good_prefix_q <= crcjrs_pkg::HEADER_LEN;
			seen_q        <= '0;
			verdict_q     <= crcjrs_pkg::ST_OK;
			tail_q        <= crcjrs_pkg::TAIL_CLEAN;
			probing_q     <= 1'b0;
			hdr_err_q     <= '0;
			bad_start_q   <= '0;
			torn_start_q  <= '0;
		end else if (take) begin
			phase_q       <= phase_n;
			off_q         <= off_n;
			ovf_q         <= ovf_n;
			rel_q         <= rel_n;
			fs_q          <= fs_n;
			crc_q         <= crc_n;
			boot_high_q   <= boot_high_n;
			boot_low_q    <= boot_low_n;
			epoch_q       <= epoch_n;
			cur_type_q    <= cur_type_n;
			cur_len_q     <= cur_len_n;
			stored_q      <= stored_n;
			cur_start_q   <= cur_start_n;
			good_prefix_q <= good_prefix_n;
			seen_q        <= seen_n;
			verdict_q     <= verdict_n;
			tail_q        <= tail_n;
			probing_q     <= probing_n;
			hdr_err_q     <= hdr_err_n;
			bad_start_q   <= bad_start_n;
			torn_start_q  <= torn_start_n;
		end
	end

endmodule

// ===== src/crcjrs_queue.sv =====
// Back part: a short result queue taking up to two results a cycle and
// presenting one at a time on the output channel. Depends on crcjrs_pkg.
`include "assert_macros.svh"

module crcjrs_queue #(
	parameter int unsigned DEPTH = crcjrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crcjrs_pkg::push_t     push,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_stall,
	output crcjrs_pkg::out_item_t out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crcjrs_pkg::out_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr1, wr2, rd_n;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    n_push;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr1       = inc(wr_q);
	assign wr2       = inc(wr1);
	assign rd_n      = inc(rd_q);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
	// A byte can raise two results, so take one only with two free slots.
	assign room      = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.v1) begin
				wr_q <= wr2;
			end else if (push.v0) begin
				wr_q <= wr1;
			end
			if (pop) begin
				rd_q <= rd_n;
			end
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	`CHK_NEVER(a_no_overfill, count_q > CW'(DEPTH), "result queue holds more than its depth")
	`CHK_PROP(a_second_needs_first, push.v1 |-> push.v0, "second result pushed without a first")
	`CHK_PROP(a_pop_drains, (pop && !push.v0) |=> (count_q == $past(count_q) - CW'(1)),
		"queue count did not fall after a lone pop")

endmodule

// ===== src/crc_journal_recovery_scanner.sv =====
// Top level of the journal recovery scanner: configuration registers, the
// parsing front part and the result queue. Depends on crcjrs_pkg.
//
//  Channel | Signals                     | Payload
//  --------+-----------------------------+------------------------------
//  input   | in_valid, in_stall          | in_data  (data_byte, final_byte)
//  output  | out_valid, out_stall        | out_data (result fields)
//  config  | cfg_we, cfg_index, cfg_data | none read back
//
// One byte is taken per cycle while in_stall is low; the CRC32C byte step and the
// field shift are combinational. A byte gives zero, one or two results; the queue
// stalls input once fewer than two slots are free, so a held output stalls the input
// after DEPTH-1 results. A result is written into the queue when its byte is taken.
// Reset returns the parser to the start of an image and the registers to defaults.
module crc_journal_recovery_scanner #(
	parameter int unsigned MAX_RECORD_LIMIT = crcjrs_pkg::MAX_RECORD_LIMIT_DEF,
	parameter int unsigned QUEUE_DEPTH      = crcjrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  crcjrs_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output crcjrs_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	logic [20:0]       max_record_len_q;
	logic [31:0]       max_image_len_q;
	logic [15:0]       expected_version_q;
	logic              room;
	logic              take;
	crcjrs_pkg::push_t push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_record_len_q   <= 21'd65536;
			max_image_len_q    <= 32'd16777216;
			expected_version_q <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				crcjrs_pkg::CFG_MAX_RECORD:  max_record_len_q   <= cfg_data[20:0];
				crcjrs_pkg::CFG_MAX_IMAGE:   max_image_len_q    <= cfg_data;
				crcjrs_pkg::CFG_EXP_VERSION: expected_version_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = !room;
	assign take     = in_valid && room;

	crcjrs_front #(
		.MAX_RECORD_LIMIT(MAX_RECORD_LIMIT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.item             (in_data),
		.max_record_len   (max_record_len_q),
		.max_image_len    (max_image_len_q),
		.expected_version (expected_version_q),
		.push             (push)
	);

	crcjrs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== tb/crc_journal_recovery_scanner_tb.sv =====
// Self-checking testbench for crc_journal_recovery_scanner: builds journal images,
// predicts header, record and summary results per byte, and checks the result channel.
// Depends on crcjrs_pkg and the scanner RTL only.
module crc_journal_recovery_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import crcjrs_pkg::*;

	localparam int unsigned REC_CEILING = MAX_RECORD_LIMIT_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MAX_RECORD;
	logic [31:0] cfg_data = '0;

	crc_journal_recovery_scanner u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	in_item_t  pending_bytes[$];
	out_item_t expected_results[$];
	int        fail_count = 0;
	int        send_idle_pct = 10;
	int        recv_idle_pct = 69;
	logic      long_hold = 1'b0;
	int        phase_no = 0;
	int unsigned cycle_count = 0;

	// Register mirror.
	logic [20:0] rec_limit_cfg = 21'd65536;
	logic [31:0] image_limit_cfg = 32'd16777216;
	logic [15:0] version_cfg = 16'd1;

	// Scanner state mirror.
	logic [63:0] scan_pos, rec_start, good_len, bad_start, torn_start;
	logic [63:0] shreg, boot_hi, boot_lo, epoch_w;
	logic [31:0] crc_acc, rec_len, rec_crc, seen_recs;
	logic [15:0] rec_type;
	logic [2:0]  scan_phase, verdict, hdr_fault;
	logic [1:0]  tail_kind;
	logic        probing;

	function automatic logic [31:0] journal_crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] v;
		v = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			v = v[0] ? ((v >> 1) ^ 32'h82F63B78) : (v >> 1);
		return v;
	endfunction

	task automatic restart_scan();
		scan_pos = 0; scan_phase = PH_HEADER; shreg = 0; crc_acc = '1;
		boot_hi = 0; boot_lo = 0; epoch_w = 0; rec_type = 0; rec_len = 0; rec_crc = 0;
		rec_start = 40; good_len = 40; seen_recs = 0; verdict = ST_OK; tail_kind = TAIL_CLEAN;
		probing = 0; hdr_fault = ST_OK; bad_start = 0; torn_start = 0;
	endtask

	task automatic mark_torn(input logic [63:0] start);
		tail_kind = TAIL_TORN;
		torn_start = start;
		scan_phase = PH_DONE;
	endtask

	task automatic push_result(input logic [1:0] kind, input logic [15:0] rtype,
			input logic [31:0] rlen, input logic [63:0] pos, input logic [63:0] bh,
			input logic [63:0] bl, input logic [63:0] ep, input logic [2:0] st,
			input logic [31:0] seen, input logic [1:0] tail, input logic [63:0] torn,
			input logic last);
		out_item_t r;
		r = '0;
		r.result_kind = kind; r.record_kind = rtype; r.record_len = rlen[20:0];
		r.position = pos[31:0]; r.boot_high = bh; r.boot_low = bl; r.epoch_value = ep;
		r.status = st; r.records_seen = seen; r.tail_state = tail;
		r.torn_bytes = torn[31:0]; r.last_result = last;
		expected_results.insert(expected_results.size(), r);
	endtask

	// Advances the scanner mirror by one image byte and queues its results.
	task automatic absorb_byte(input in_item_t it);
		logic [7:0]  b;
		logic [63:0] off, rel, nxt, size, torn;
		logic [31:0] lim;
		logic        finish, good;
		int          i, sh;
		b = it.data_byte;
		off = scan_pos;
		lim = (32'(rec_limit_cfg) > REC_CEILING) ? REC_CEILING : 32'(rec_limit_cfg);
		finish = 0;
		if (scan_phase == PH_HEADER) begin
			i = int'(off);
			sh = (i < 8 || i >= 32) ? 8 * (i % 4) : 8 * (i % 8);
			if (i == 0 || i == 4 || i == 8 || i == 16 || i == 24 || i == 32)
				shreg = 0;
			shreg |= 64'(b) << sh;
			if (i < 32)
				crc_acc = journal_crc_step(crc_acc, b);
			if (i == 3 && shreg[31:0] != JOURNAL_MAGIC && hdr_fault == ST_OK)
				hdr_fault = ST_MAGIC_BAD;
			if (i == 5 && shreg[31:0] != {16'd0, version_cfg} && hdr_fault == ST_OK)
				hdr_fault = ST_VERSION_BAD;
			if (i == 15) boot_hi = shreg;
			if (i == 23) boot_lo = shreg;
			if (i == 31) epoch_w = shreg;
			if (i == 35 && shreg[31:0] != ~crc_acc && hdr_fault == ST_OK)
				hdr_fault = ST_HDR_CRC_BAD;
			if (i == 39) begin
				if (hdr_fault != ST_OK) begin
					verdict = hdr_fault;
					scan_phase = PH_DONE;
				end else begin
					push_result(KIND_HEADER, 0, 0, 40, boot_hi, boot_lo, epoch_w,
						ST_OK, 0, TAIL_CLEAN, 0, 0);
					scan_phase = PH_RECORD;
					rec_start = 40;
					good_len = 40;
				end
			end
		end else if (scan_phase == PH_RECORD) begin
			rel = off - rec_start;
			if (rel == 0) begin
				crc_acc = '1;
				shreg = 0;
				if (!probing) seen_recs++;
			end
			if (rel < 10) begin
				sh = rel < 2 ? 8 * int'(rel) : rel < 6 ? 8 * int'(rel - 2) : 8 * int'(rel - 6);
				shreg |= 64'(b) << sh;
				if (rel < 6) crc_acc = journal_crc_step(crc_acc, b);
				if (rel == 1) begin rec_type = shreg[15:0]; shreg = 0; end
				if (rel == 5) begin rec_len = shreg[31:0]; shreg = 0; end
				if (rel == 9) begin
					rec_crc = shreg[31:0];
					if (rec_len > lim)
						mark_torn(probing ? bad_start : rec_start);
					else if (rec_len == 0)
						finish = 1;
				end
			end else begin
				crc_acc = journal_crc_step(crc_acc, b);
				if (rel - 10 == 64'(rec_len) - 1) finish = 1;
			end
			if (finish) begin
				good = (~crc_acc == rec_crc);
				nxt = rec_start + 10 + 64'(rec_len);
				if (!probing) begin
					if (good) begin
						push_result(KIND_RECORD, rec_type, rec_len, rec_start, 0, 0, 0,
							ST_OK, seen_recs, TAIL_CLEAN, 0, 0);
						good_len = nxt;
					end else begin
						// The following record decides between corruption and a torn tail.
						probing = 1;
						bad_start = rec_start;
					end
					rec_start = nxt;
				end else if (good) begin
					verdict = ST_CORRUPT;
					tail_kind = TAIL_MID;
					scan_phase = PH_DONE;
				end else begin
					mark_torn(bad_start);
				end
			end
		end
		scan_pos = off + 1;
		if (it.final_byte) begin
			size = off + 1;
			torn = 0;
			if (size > 64'(image_limit_cfg))
				push_result(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, ST_TOO_LARGE, 0, TAIL_CLEAN, 0, 1);
			else if (scan_phase == PH_HEADER)
				push_result(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, ST_HDR_SHORT, 0, TAIL_CLEAN, 0, 1);
			else if (verdict >= ST_HDR_SHORT && verdict <= ST_HDR_CRC_BAD)
				push_result(KIND_SUMMARY, 0, 0, 0, 0, 0, 0, verdict, 0, TAIL_CLEAN, 0, 1);
			else begin
				if (scan_phase == PH_RECORD) begin
					if (probing) mark_torn(bad_start);
					else if (size > rec_start) mark_torn(rec_start);
				end
				if (tail_kind == TAIL_TORN) torn = size - torn_start;
				push_result(KIND_SUMMARY, 0, 0, good_len, 0, 0, 0, verdict, seen_recs,
					tail_kind, torn, 1);
			end
			restart_scan();
		end
	endtask

	// Image construction.
	logic [7:0] img[$];

	task automatic put_le(input logic [63:0] v, input int nbytes);
		for (int k = 0; k < nbytes; k++) img.insert(img.size(), v[8*k +: 8]);
	endtask

	function automatic logic [31:0] crc_over(input int from, input int count);
		logic [31:0] c;
		c = '1;
		for (int k = 0; k < count; k++) c = journal_crc_step(c, img[from + k]);
		return ~c;
	endfunction

	// hdr_case: 0 good, 1 magic bad, 2 version bad, 3 crc bad.
	task automatic build_header(input int hdr_case);
		logic [15:0] ver;
		int k;
		img.delete();
		put_le(JOURNAL_MAGIC, 4);
		if (hdr_case == 1) begin
			k = $urandom_range(0, 31);
			img[k / 8] ^= 8'(1 << (k % 8));
		end
		ver = version_cfg;
		if (hdr_case == 2) ver ^= 16'($urandom_range(1, 65535));
		put_le(ver, 2);
		put_le($urandom, 2);
		put_le({$urandom, $urandom}, 8);
		put_le({$urandom, $urandom}, 8);
		put_le({$urandom, $urandom}, 8);
		put_le(crc_over(0, 32), 4);
		if (hdr_case == 3) begin
			k = $urandom_range(0, 31);
			img[32 + k / 8] ^= 8'(1 << (k % 8));
		end
		put_le($urandom, 4);
	endtask

	task automatic add_record(input int len, input logic oversize, input logic damage);
		int s, k;
		logic [31:0] lenf, lim;
		lim = (32'(rec_limit_cfg) > REC_CEILING) ? REC_CEILING : 32'(rec_limit_cfg);
		s = img.size();
		lenf = oversize ? ((lim == 32'hFFFFFFFF) ? lim : lim + $urandom_range(1, 3)) : len;
		put_le($urandom, 2);
		put_le(lenf, 4);
		put_le(0, 4);
		for (int p = 0; p < len; p++) img.insert(img.size(), 8'($urandom));
		lenf = crc_over(s, 6);
		begin
			logic [31:0] c;
			c = '1;
			for (int p = 0; p < 6; p++) c = journal_crc_step(c, img[s + p]);
			for (int p = 0; p < len; p++) c = journal_crc_step(c, img[s + 10 + p]);
			lenf = ~c;
		end
		for (int p = 0; p < 4; p++) img[s + 6 + p] = lenf[8*p +: 8];
		if (damage) begin
			// Damage the payload or the stored check word only, so the length stays sane.
			k = (len > 0 && $urandom_range(0, 1)) ? s + 10 + $urandom_range(0, len - 1)
				: s + 6 + $urandom_range(0, 3);
			img[k] ^= 8'(1 << $urandom_range(0, 7));
		end
	endtask

	task automatic queue_image();
		in_item_t it;
		for (int k = 0; k < img.size(); k++) begin
			it.data_byte = img[k];
			it.final_byte = (k == img.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
		end
	endtask

	task automatic random_image();
		int r, nrec, bad_idx, maxlen, cut;
		logic [31:0] lim;
		lim = (32'(rec_limit_cfg) > REC_CEILING) ? REC_CEILING : 32'(rec_limit_cfg);
		r = $urandom_range(0, 19);
		build_header(r < 3 ? r + 1 : 0);
		if (r == 3) begin
			img = img[0 : $urandom_range(0, 38)];
		end else begin
			nrec = $urandom_range(0, 4);
			bad_idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nrec) : -1;
			maxlen = (lim < 12) ? int'(lim) : 12;
			for (int n = 0; n < nrec; n++)
				add_record($urandom_range(0, maxlen), $urandom_range(0, 11) == 0, n == bad_idx);
			r = $urandom_range(0, 9);
			if (r == 0 && img.size() > 41) begin
				cut = $urandom_range(40, img.size() - 1);
				img = img[0 : cut - 1];
			end else if (r == 1) begin
				repeat ($urandom_range(1, 12)) img.insert(img.size(), 8'($urandom));
			end
		end
		queue_image();
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MAX_RECORD:  rec_limit_cfg = val[20:0];
			CFG_MAX_IMAGE:   image_limit_cfg = val;
			CFG_EXP_VERSION: version_cfg = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input int nbytes);
		int start;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < nbytes) random_image();
		drain();
	endtask

	// Sender.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				absorb_byte(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and result checker.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: %h", out_data);
				end else begin
					out_item_t want;
					want = expected_results.pop_front();
					if (out_data.result_kind !== want.result_kind ||
							out_data.record_kind !== want.record_kind ||
							out_data.record_len !== want.record_len ||
							out_data.position !== want.position ||
							out_data.boot_high !== want.boot_high ||
							out_data.boot_low !== want.boot_low ||
							out_data.epoch_value !== want.epoch_value ||
							out_data.status !== want.status ||
							out_data.records_seen !== want.records_seen ||
							out_data.tail_state !== want.tail_state ||
							out_data.torn_bytes !== want.torn_bytes ||
							out_data.last_result !== want.last_result) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch: expected %p actual %p", want, out_data);
					end
				end
			end
			out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Long receiver hold-off while the directed images keep coming, so the result queue fills.
	initial begin
		wait (phase_no == 0 && arst_n);
		repeat (20) @(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		restart_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed images under reset defaults.
		build_header(0);
		queue_image();                       // header ends on the final byte
		build_header(0);
		add_record(0, 0, 0);
		add_record(5, 0, 0);
		queue_image();                       // record completes on the final byte
		img.delete();
		img.insert(0, 8'hFF);
		queue_image();                       // one-byte image
		build_header(0);
		add_record(3, 0, 1);
		add_record(2, 0, 0);
		queue_image();                       // mid-file corruption
		build_header(0);
		add_record(3, 0, 1);
		add_record(2, 0, 1);
		queue_image();                       // bad record then bad probe
		build_header(0);
		add_record(4, 1, 0);
		queue_image();                       // length above the limit
		for (int h = 1; h <= 3; h++) begin
			build_header(h);
			queue_image();
		end
		drain();
		run_phase(60);

		phase_no = 1;
		write_reg(CFG_MAX_RECORD, 32'd0);
		write_reg(CFG_MAX_IMAGE, 32'hFFFFFFFF);
		write_reg(CFG_EXP_VERSION, 32'd0);
		run_phase(60);

		phase_no = 2;
		send_idle_pct = 69;
		recv_idle_pct = 10;
		write_reg(CFG_MAX_RECORD, 32'h1FFFFF);
		write_reg(CFG_MAX_IMAGE, 32'd40);
		write_reg(CFG_EXP_VERSION, 32'hFFFF);
		run_phase(60);

		phase_no = 3;
		write_reg(CFG_MAX_RECORD, 32'd6);
		write_reg(CFG_MAX_IMAGE, 32'd70);
		write_reg(CFG_EXP_VERSION, 32'($urandom_range(0, 65535)));
		run_phase(60);

		phase_no = 4;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_MAX_RECORD, 32'd1048576);
		write_reg(CFG_MAX_IMAGE, 32'd5000);
		write_reg(CFG_EXP_VERSION, 32'd1);
		run_phase(60);

		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
